// ----- rtl/mrma_pkg.sv -----
// Package for the memory region map allocator: sizes, codes, command FSM states.
// No dependencies.
package mrma_pkg;

	localparam int MaxRegions = 32;
	localparam int PageBits   = 12;
	localparam int AddrBits   = 48;
	localparam int IdxBits    = $clog2(MaxRegions);
	localparam int CntBits    = $clog2(MaxRegions + 1);
	localparam int KindBits   = 32;
	localparam int EntryBits  = 2 * AddrBits + KindBits;

	localparam logic [AddrBits-1:0] AddrMax = {AddrBits{1'b1}};
	localparam logic [AddrBits-1:0] PgMask  = AddrBits'((64'd1 << PageBits) - 64'd1);

	localparam logic [KindBits-1:0] KindRam      = 32'd1;
	localparam logic [KindBits-1:0] KindReserved = 32'd2;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_ALLOC  = 2'd1,
		CMD_CARVE  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_FIT   = 3'd1,
		ST_ZERO     = 3'd2,
		ST_FULL     = 3'd3,
		ST_SPLIT    = 3'd4,
		ST_BAD_IDX  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,      // read issued
		S_RDW,     // read data valid, evaluate
		S_ALLOC_WR2,
		S_CARVE_CHK,
		S_CARVE_HIT,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_CARVE_FIN,
		S_DONE,
		S_OUT
	} state_t;

	function automatic logic [AddrBits-1:0] sat_add(logic [AddrBits-1:0] a,
			logic [AddrBits-1:0] b);
		logic [AddrBits:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AddrBits] ? AddrMax : s[AddrBits-1:0];
	endfunction

endpackage

// ----- rtl/mrma_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module mrma_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/memory_region_map_allocator.sv -----
// Memory region map allocator: region table in one RAM, command sequencer.
// Depends on mrma_pkg and mrma_ram.
// Allocate scans entries from the top down. Carve scans entries from the bottom up, then
// on insert shifts the entries above the hit up by one.
// One command at a time; a new command is taken once the result has been handed over.
// Reset (arst_n low) clears entry count, RAM total and control; table contents
// are undefined until written.
module memory_region_map_allocator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: command[1:0], address[49:2], size[97:50], max_address[145:98],
	// region_type[177:146], entry_index[185:178], zero fill to 192
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: status[2:0], result_address[50:3], result_length[98:51],
	// result_type[130:99], entry_total[139:131], ram_total[187:140], zero fill
	output logic [191:0] m_tdata
);
	localparam int AB = mrma_pkg::AddrBits;
	localparam int IB = mrma_pkg::IdxBits;
	localparam int CB = mrma_pkg::CntBits;
	localparam int KB = mrma_pkg::KindBits;
	localparam int EB = mrma_pkg::EntryBits;

	mrma_pkg::state_t state_q, state_d;

	// command fields
	mrma_pkg::cmd_t cmd_q;
	logic [AB-1:0] addr_q, limit_q;
	logic [7:0]    idx_q;

	logic [CB-1:0] cnt_q, cnt_d;
	logic [AB-1:0] sum_q, sum_d;

	// scan/work registers
	logic [CB-1:0] ptr_q, ptr_d;       // alloc: n (entries left); carve: i
	logic [CB-1:0] hit_q, hit_d;
	logic          found_q, found_d;
	logic          blocked_q, blocked_d;
	logic [AB-1:0] rsz_q, rsz_d;       // rounded alloc size / carve hi
	logic [AB-1:0] lo_q, lo_d;
	logic          bad_q, bad_d;       // up-front carve failure
	logic [AB-1:0] nb_q, nb_d, nl_q, nl_d;
	logic [EB-1:0] hold_q, hold_d;     // entry being split (carve hit)

	// result
	logic [2:0]    rst_q, rst_d;
	logic [AB-1:0] raddr_q, raddr_d, rlen_q, rlen_d;
	logic [KB-1:0] rkind_q, rkind_d;

	// RAM
	logic          we;
	logic [IB-1:0] waddr, raddr;
	logic [EB-1:0] wdata, rdata;

	mrma_ram #(.Width(EB), .Depth(mrma_pkg::MaxRegions)) u_tbl (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [AB-1:0] e_base, e_len, e_end;
	logic [KB-1:0] e_kind;
	assign e_base = rdata[AB-1:0];
	assign e_len  = rdata[2*AB-1:AB];
	assign e_kind = rdata[EB-1:2*AB];
	assign e_end  = mrma_pkg::sat_add(e_base, e_len);

	// alloc span of the current entry
	logic          st_ok;
	logic [AB-1:0] e_start, e_stop, e_span;
	logic [AB:0]   e_need;
	assign st_ok   = e_base <= (mrma_pkg::AddrMax - mrma_pkg::PgMask);
	assign e_start = (e_base + mrma_pkg::PgMask) & ~mrma_pkg::PgMask;
	assign e_stop  = e_end & ~mrma_pkg::PgMask;
	assign e_span  = (e_stop > e_start) ? e_stop - e_start : '0;
	assign e_need  = {1'b0, e_start} + {1'b0, rsz_q};

	// input unpacking
	logic [1:0]    in_cmd;
	logic [AB-1:0] in_addr, in_size, in_limit;
	assign in_cmd   = s_tdata[1:0];
	assign in_addr  = s_tdata[49:2];
	assign in_size  = s_tdata[97:50];
	assign in_limit = s_tdata[145:98];

	logic [AB:0] c_end;
	assign c_end = {1'b0, in_addr} + {1'b0, in_size};

	assign s_tready = (state_q == mrma_pkg::S_IDLE);
	assign m_tvalid = (state_q == mrma_pkg::S_OUT);
	assign m_tdata  = {4'd0, sum_q, 9'(cnt_q), rkind_q, rlen_q, raddr_q, rst_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrma_pkg::S_IDLE;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= mrma_pkg::cmd_t'(in_cmd);
			addr_q  <= in_addr;
			limit_q <= in_limit;
			idx_q   <= s_tdata[185:178];
		end
		ptr_q <= ptr_d; hit_q <= hit_d; found_q <= found_d; blocked_q <= blocked_d;
		rsz_q <= rsz_d; lo_q <= lo_d; bad_q <= bad_d; nb_q <= nb_d; nl_q <= nl_d;
		hold_q <= hold_d;
		rst_q <= rst_d; raddr_q <= raddr_d; rlen_q <= rlen_d; rkind_q <= rkind_d;
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q; sum_d = sum_q;
		ptr_d = ptr_q; hit_d = hit_q; found_d = found_q; blocked_d = blocked_q;
		rsz_d = rsz_q; lo_d = lo_q; bad_d = bad_q; nb_d = nb_q; nl_d = nl_q;
		hold_d = hold_q;
		rst_d = rst_q; raddr_d = raddr_q; rlen_d = rlen_q; rkind_d = rkind_q;
		we = 1'b0; waddr = '0; wdata = '0; raddr = '0;

		unique case (state_q)
			mrma_pkg::S_IDLE: begin
				if (s_tvalid) begin
					rst_d = mrma_pkg::ST_OK; raddr_d = '0; rlen_d = '0; rkind_d = '0;
					found_d = 1'b0; blocked_d = 1'b0;
					rsz_d = (in_size + mrma_pkg::PgMask) & ~mrma_pkg::PgMask;
					unique case (mrma_pkg::cmd_t'(in_cmd))
						mrma_pkg::CMD_APPEND: begin
							if (cnt_q >= CB'(mrma_pkg::MaxRegions)) begin
								rst_d = mrma_pkg::ST_FULL;
							end else begin
								we = 1'b1; waddr = cnt_q[IB-1:0];
								wdata = {s_tdata[177:146], in_size, in_addr};
								cnt_d = cnt_q + 1'b1;
								if (s_tdata[177:146] == mrma_pkg::KindRam)
									sum_d = mrma_pkg::sat_add(sum_q, in_size);
							end
							state_d = mrma_pkg::S_DONE;
						end
						mrma_pkg::CMD_ALLOC: begin
							ptr_d = cnt_q;
							if (in_size > mrma_pkg::AddrMax - mrma_pkg::PgMask) begin
								rst_d = mrma_pkg::ST_NO_FIT;
								state_d = mrma_pkg::S_DONE;
							end else begin
								state_d = mrma_pkg::S_RD;
							end
						end
						mrma_pkg::CMD_CARVE: begin
							ptr_d = '0;
							lo_d = in_addr & ~mrma_pkg::PgMask;
							rsz_d = (c_end[AB-1:0] + mrma_pkg::PgMask) & ~mrma_pkg::PgMask;
							bad_d = c_end[AB] ||
								(c_end[AB-1:0] > mrma_pkg::AddrMax - mrma_pkg::PgMask);
							state_d = mrma_pkg::S_RD;
						end
						mrma_pkg::CMD_READ: begin
							ptr_d = CB'(s_tdata[185:178] & 8'(mrma_pkg::MaxRegions - 1));
							state_d = mrma_pkg::S_RD;
						end
					endcase
				end
			end
			mrma_pkg::S_RD: begin
				// issue table read for the current step, or finish the scan
				unique case (cmd_q)
					mrma_pkg::CMD_ALLOC: begin
						if (ptr_q == '0) begin
							rst_d = blocked_q ? mrma_pkg::ST_FULL : mrma_pkg::ST_NO_FIT;
							state_d = mrma_pkg::S_DONE;
						end else begin
							raddr = IB'(ptr_q - 1'b1);
							state_d = mrma_pkg::S_RDW;
						end
					end
					mrma_pkg::CMD_CARVE: begin
						if (bad_q) begin
							rst_d = mrma_pkg::ST_SPLIT;
							state_d = mrma_pkg::S_DONE;
						end else if (ptr_q >= cnt_q) begin
							state_d = found_q ? mrma_pkg::S_CARVE_HIT : mrma_pkg::S_DONE;
						end else begin
							raddr = ptr_q[IB-1:0];
							state_d = mrma_pkg::S_RDW;
						end
					end
					mrma_pkg::CMD_READ: begin
						raddr = ptr_q[IB-1:0];
						state_d = mrma_pkg::S_RDW;
					end
					default: state_d = mrma_pkg::S_DONE;
				endcase
			end
			mrma_pkg::S_RDW: begin
				state_d = mrma_pkg::S_RD;
				unique case (cmd_q)
					mrma_pkg::CMD_ALLOC: begin
						ptr_d = ptr_q - 1'b1;
						if (st_ok && e_kind == mrma_pkg::KindRam && e_span >= rsz_q &&
							e_need <= {1'b0, limit_q}) begin
							if (e_span == rsz_q) begin
								we = 1'b1; waddr = IB'(ptr_q - 1'b1);
								wdata = {mrma_pkg::KindReserved, e_len, e_base};
								raddr_d = e_start;
								rst_d = (e_start == '0) ? mrma_pkg::ST_ZERO : mrma_pkg::ST_OK;
								if (e_start == '0) raddr_d = '0;
								state_d = mrma_pkg::S_DONE;
							end else if (e_stop <= limit_q) begin
								if (cnt_q < CB'(mrma_pkg::MaxRegions)) begin
									nb_d = e_stop - rsz_q;
									nl_d = e_end - (e_stop - rsz_q);
									we = 1'b1; waddr = IB'(ptr_q - 1'b1);
									wdata = {e_kind, e_len - (e_end - (e_stop - rsz_q)), e_base};
									state_d = mrma_pkg::S_ALLOC_WR2;
								end else begin
									blocked_d = 1'b1;
								end
							end
						end
					end
					mrma_pkg::CMD_CARVE: begin
						ptr_d = ptr_q + 1'b1;
						if (!(e_kind != mrma_pkg::KindRam || e_end <= lo_q ||
							e_base >= rsz_q)) begin
							if (!(e_base <= lo_q && e_end >= rsz_q)) begin
								rst_d = mrma_pkg::ST_SPLIT;
								state_d = mrma_pkg::S_DONE;
							end else if (!found_q) begin
								found_d = 1'b1; hit_d = ptr_q;
								hold_d = rdata;
							end
						end
					end
					mrma_pkg::CMD_READ: begin
						if (idx_q >= 8'(cnt_q) || idx_q >= 8'(mrma_pkg::MaxRegions)) begin
							rst_d = mrma_pkg::ST_BAD_IDX;
						end else begin
							raddr_d = e_base; rlen_d = e_len; rkind_d = e_kind;
						end
						state_d = mrma_pkg::S_DONE;
					end
					default: state_d = mrma_pkg::S_DONE;
				endcase
			end
			mrma_pkg::S_ALLOC_WR2: begin
				we = 1'b1; waddr = cnt_q[IB-1:0];
				wdata = {mrma_pkg::KindReserved, nl_q, nb_q};
				cnt_d = cnt_q + 1'b1;
				rst_d = (nb_q == '0) ? mrma_pkg::ST_ZERO : mrma_pkg::ST_OK;
				raddr_d = (nb_q == '0) ? '0 : nb_q;
				state_d = mrma_pkg::S_DONE;
			end
			mrma_pkg::S_CARVE_HIT: begin
				// hold_q = hit entry
				nb_d = mrma_pkg::sat_add(hold_q[AB-1:0], hold_q[2*AB-1:AB]); // entry end
				if (rsz_q < mrma_pkg::sat_add(hold_q[AB-1:0], hold_q[2*AB-1:AB])) begin
					if (cnt_q >= CB'(mrma_pkg::MaxRegions)) begin
						rst_d = mrma_pkg::ST_FULL;
						state_d = mrma_pkg::S_DONE;
					end else begin
						ptr_d = cnt_q;  // shift entries [hit+1, cnt) up by one
						state_d = mrma_pkg::S_SHIFT_RD;
					end
				end else begin
					state_d = mrma_pkg::S_CARVE_FIN;
				end
			end
			mrma_pkg::S_SHIFT_RD: begin
				if (ptr_q == hit_q + 1'b1) begin
					we = 1'b1; waddr = ptr_q[IB-1:0];
					wdata = {mrma_pkg::KindRam, nb_q - rsz_q, rsz_q};
					cnt_d = cnt_q + 1'b1;
					state_d = mrma_pkg::S_CARVE_FIN;
				end else begin
					raddr = IB'(ptr_q - 1'b1);
					state_d = mrma_pkg::S_SHIFT_WR;
				end
			end
			mrma_pkg::S_SHIFT_WR: begin
				we = 1'b1; waddr = ptr_q[IB-1:0]; wdata = rdata;
				ptr_d = ptr_q - 1'b1;
				state_d = mrma_pkg::S_SHIFT_RD;
			end
			mrma_pkg::S_CARVE_FIN: begin
				we = 1'b1; waddr = hit_q[IB-1:0];
				wdata = {hold_q[EB-1:2*AB], lo_q - hold_q[AB-1:0], hold_q[AB-1:0]};
				state_d = mrma_pkg::S_DONE;
			end
			mrma_pkg::S_DONE: begin
				if (cmd_q == mrma_pkg::CMD_CARVE && rst_q == mrma_pkg::ST_OK)
					raddr_d = addr_q;
				state_d = mrma_pkg::S_OUT;
			end
			mrma_pkg::S_OUT: begin
				if (m_tready) state_d = mrma_pkg::S_IDLE;
			end
			default: state_d = mrma_pkg::S_IDLE;
		endcase
	end
endmodule

// ----- dv/tb_memory_region_map_allocator.sv -----
// Testbench for memory_region_map_allocator: drives command transactions, predicts each
// result with a table model kept here, and compares every result transaction field by field.
// Depends on mrma_pkg and the RTL of the block.
module tb_memory_region_map_allocator;

	localparam logic [47:0] PG = 48'hFFF;
	localparam logic [47:0] TOP = 48'hFFFF_FFFF_FFFF;
	localparam int MR = mrma_pkg::MaxRegions;

	// packed from the top bit down, so status lands in the low bits
	typedef struct packed {
		logic [47:0] ram;
		logic [8:0]  total;
		logic [31:0] kind;
		logic [47:0] len;
		logic [47:0] addr;
		logic [2:0]  status;
	} map_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;

	// model copy of the region table
	logic [47:0] map_base [MR];
	logic [47:0] map_len  [MR];
	logic [31:0] map_kind [MR];
	int          map_count;
	logic [47:0] map_ram;

	map_result_t expected_q[$];
	int          errors = 0;
	int          send_idle = 24;
	int          recv_idle = 86;
	int          hold_cycles = 0;

	memory_region_map_allocator dut (.*);

	always #2 clk = ~clk;

	function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? TOP : s[47:0];
	endfunction

	function automatic bit page_up(logic [47:0] x, output logic [47:0] r);
		if (x > TOP - PG) return 0;
		r = (x + PG) & ~PG;
		return 1;
	endfunction

	function automatic logic [2:0] alloc_top_down(logic [47:0] req, logic [47:0] lim,
			output logic [47:0] where);
		logic [47:0] sz, start, top, stop, span, nb, nl;
		bit blocked;
		blocked = 0;
		where = '0;
		if (!page_up(req, sz)) return mrma_pkg::ST_NO_FIT;
		for (int i = map_count - 1; i >= 0; i--) begin
			if (!page_up(map_base[i], start)) continue;
			top = add_sat(map_base[i], map_len[i]);
			stop = top & ~PG;
			span = (stop > start) ? stop - start : '0;
			// start+size is summed in 49 bits, so a carry past the top of the space is kept
			if (map_kind[i] != mrma_pkg::KindRam || span < sz ||
				{1'b0, start} + sz > {1'b0, lim})
				continue;
			if (span == sz) begin
				map_kind[i] = mrma_pkg::KindReserved;
				where = start;
				return (start == 0) ? mrma_pkg::ST_ZERO : mrma_pkg::ST_OK;
			end
			if (stop <= lim) begin
				if (map_count < MR) begin
					nb = stop - sz;
					nl = top - nb;
					map_len[i] -= nl;
					map_base[map_count] = nb;
					map_len[map_count] = nl;
					map_kind[map_count] = mrma_pkg::KindReserved;
					map_count++;
					where = nb;
					return (nb == 0) ? mrma_pkg::ST_ZERO : mrma_pkg::ST_OK;
				end
				blocked = 1;
			end
		end
		return blocked ? mrma_pkg::ST_FULL : mrma_pkg::ST_NO_FIT;
	endfunction

	function automatic logic [2:0] carve_range(logic [47:0] a, logic [47:0] sz);
		logic [47:0] lo, hi, es, ee;
		int hit;
		hit = -1;
		if (sz > TOP - a) return mrma_pkg::ST_SPLIT;
		lo = a & ~PG;
		if (!page_up(a + sz, hi)) return mrma_pkg::ST_SPLIT;
		for (int i = 0; i < map_count; i++) begin
			es = map_base[i];
			ee = add_sat(map_base[i], map_len[i]);
			if (map_kind[i] != mrma_pkg::KindRam || ee <= lo || es >= hi) continue;
			if (!(es <= lo && ee >= hi)) return mrma_pkg::ST_SPLIT;
			if (hit < 0) hit = i;
		end
		if (hit < 0) return mrma_pkg::ST_OK;
		es = map_base[hit];
		ee = add_sat(map_base[hit], map_len[hit]);
		if (hi < ee) begin
			if (map_count >= MR) return mrma_pkg::ST_FULL;
			for (int j = map_count; j > hit + 1; j--) begin
				map_base[j] = map_base[j-1];
				map_len[j] = map_len[j-1];
				map_kind[j] = map_kind[j-1];
			end
			map_base[hit+1] = hi;
			map_len[hit+1] = ee - hi;
			map_kind[hit+1] = mrma_pkg::KindRam;
			map_count++;
		end
		map_len[hit] = lo - es;
		return mrma_pkg::ST_OK;
	endfunction

	function automatic map_result_t predict_command(mrma_pkg::cmd_t c, logic [47:0] a,
			logic [47:0] sz, logic [47:0] lim, logic [31:0] k, logic [7:0] idx);
		map_result_t r;
		logic [47:0] where;
		r = '0;
		case (c)
			mrma_pkg::CMD_APPEND: begin
				if (map_count >= MR) r.status = mrma_pkg::ST_FULL;
				else begin
					map_base[map_count] = a;
					map_len[map_count] = sz;
					map_kind[map_count] = k;
					map_count++;
					if (k == mrma_pkg::KindRam) map_ram = add_sat(map_ram, sz);
				end
			end
			mrma_pkg::CMD_ALLOC: begin
				r.status = alloc_top_down(sz, lim, where);
				if (r.status == mrma_pkg::ST_OK) r.addr = where;
			end
			mrma_pkg::CMD_CARVE: begin
				r.status = carve_range(a, sz);
				if (r.status == mrma_pkg::ST_OK) r.addr = a;
			end
			default: begin
				if (idx >= map_count) r.status = mrma_pkg::ST_BAD_IDX;
				else begin
					r.addr = map_base[idx];
					r.len = map_len[idx];
					r.kind = map_kind[idx];
				end
			end
		endcase
		r.total = 9'(map_count);
		r.ram = map_ram;
		return r;
	endfunction

	task automatic send_command(mrma_pkg::cmd_t c, logic [47:0] a, logic [47:0] sz,
			logic [47:0] lim, logic [31:0] k, logic [7:0] idx);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, idx, k, lim, sz, a, c};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.push_back(predict_command(c, a, sz, lim, k, idx));
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// result checker
	always @(posedge clk) begin
		map_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[187:0];
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.addr !== want.addr) begin
					$display("%0t: address exp %h got %h", $time, want.addr, got.addr);
					errors++;
				end
				if (got.len !== want.len) begin
					$display("%0t: length exp %h got %h", $time, want.len, got.len);
					errors++;
				end
				if (got.kind !== want.kind) begin
					$display("%0t: type exp %h got %h", $time, want.kind, got.kind);
					errors++;
				end
				if (got.total !== want.total) begin
					$display("%0t: entries exp %0d got %0d", $time, want.total, got.total);
					errors++;
				end
				if (got.ram !== want.ram) begin
					$display("%0t: ram total exp %h got %h", $time, want.ram, got.ram);
					errors++;
				end
			end
		end
	end

	task automatic drain;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// random page-ish address, mostly small so regions interact
	function automatic logic [47:0] rand_addr();
		case ($urandom_range(4))
			0: return {$urandom, $urandom} & TOP;
			1: return 48'(($urandom_range(64)) << 12);
			default: return 48'(($urandom_range(64) << 12) + $urandom_range(3) * 48'h800);
		endcase
	endfunction

	function automatic logic [47:0] rand_size();
		case ($urandom_range(5))
			0: return {$urandom, $urandom} & TOP;
			1: return '0;
			default: return 48'($urandom_range(16) << 12) +
				48'($urandom_range(1) * $urandom_range(4095));
		endcase
	endfunction

	task automatic test_directed;
		send_command(mrma_pkg::CMD_READ, 0, 0, 0, 0, 8'd0);     // read of an empty table
		send_command(mrma_pkg::CMD_APPEND, 48'h0, 48'h4000, 0, mrma_pkg::KindRam, 0);
		send_command(mrma_pkg::CMD_ALLOC, 0, 48'h4000, TOP, 0, 0);   // exact fit at zero
		send_command(mrma_pkg::CMD_APPEND, 48'h10_0000, 48'h10_0000, 0, mrma_pkg::KindRam, 0);
		send_command(mrma_pkg::CMD_APPEND, TOP - 48'h2000, TOP, 0, mrma_pkg::KindRam, 0);
		send_command(mrma_pkg::CMD_APPEND, 48'h5000, 48'h1000, 0, mrma_pkg::KindReserved, 0);
		send_command(mrma_pkg::CMD_APPEND, 48'h9000, 48'h1000, 0, 32'hFFFF_FFFF, 0);
		send_command(mrma_pkg::CMD_ALLOC, 0, TOP, TOP, 0, 0);          // round-up overflow
		send_command(mrma_pkg::CMD_ALLOC, 0, 48'h1, 48'h1F_FFFF, 0, 0); // no fit: the split would end above the limit
		send_command(mrma_pkg::CMD_ALLOC, 0, 48'h0, TOP, 0, 0);        // size zero
		send_command(mrma_pkg::CMD_ALLOC, 0, 48'h2000, 48'h1000, 0, 0); // no fit under limit
		send_command(mrma_pkg::CMD_CARVE, 48'h12_0000, 48'h2000, 0, 0, 0); // carve inside
		send_command(mrma_pkg::CMD_CARVE, TOP, 48'h2, 0, 0, 0);        // past the top
		send_command(mrma_pkg::CMD_CARVE, TOP - 48'h10, 48'h1, 0, 0, 0); // round-up overflow
		send_command(mrma_pkg::CMD_CARVE, 48'hF_F000, 48'h3000, 0, 0, 0); // overlaps an edge
		send_command(mrma_pkg::CMD_CARVE, 48'h7_0000, 48'h1000, 0, 0, 0); // touches nothing
		send_command(mrma_pkg::CMD_READ, 0, 0, 0, 0, 8'hFF);
		for (int i = 0; i < 8; i++) send_command(mrma_pkg::CMD_READ, 0, 0, 0, 0, 8'(i));
		drain();
	endtask

	// fill the table and hit the full cases for append, allocate and carve
	task automatic test_full_table;
		while (map_count < MR)
			send_command(mrma_pkg::CMD_APPEND, 48'h100_0000, 48'h4000, 0, mrma_pkg::KindRam, 0);
		send_command(mrma_pkg::CMD_APPEND, 0, 0, 0, mrma_pkg::KindRam, 0);
		send_command(mrma_pkg::CMD_ALLOC, 0, 48'h1000, TOP, 0, 0);
		send_command(mrma_pkg::CMD_CARVE, 48'h20_0000, 48'h1000, 0, 0, 0);
		send_command(mrma_pkg::CMD_READ, 0, 0, 0, 0, 8'(MR - 1));
		drain();
	endtask

	task automatic test_random(int n);
		mrma_pkg::cmd_t c;
		for (int i = 0; i < n; i++) begin
			c = mrma_pkg::cmd_t'($urandom_range(3));
			send_command(c, rand_addr(), rand_size(),
				($urandom_range(3) == 0) ? {$urandom, $urandom} & TOP :
					48'($urandom_range(80) << 12),
				($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1, 2)),
				($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(map_count)));
		end
		drain();
	endtask

	// receiver holds off while commands keep coming
	task automatic test_backpressure;
		hold_cycles = 400;
		for (int i = 0; i < 10; i++)
			send_command(mrma_pkg::CMD_READ, 0, 0, 0, 0, 8'($urandom_range(40)));
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		map_count = 0;
		map_ram = '0;
		test_directed();
		test_random(130);
		send_idle = 86;
		recv_idle = 24;
		test_full_table();
		test_random(120);
		test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		test_random(100);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mrma_pkg.sv
rtl/mrma_ram.sv
rtl/memory_region_map_allocator.sv
dv/tb_memory_region_map_allocator.sv
